@@ sv/red_pkg.sv @@
package red_pkg;

    // Default width of the elapsed-time counters.
    localparam int TIME_WIDTH_DEF = 16;

    // Width of each timing register.
    localparam int CFG_WIDTH = 16;

    // Width of the register index on the configuration channel.
    localparam int CFG_INDEX_WIDTH = 2;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_DATA_WIDTH  = 8;
    localparam int OUT_DATA_WIDTH = 8;

    // Register indexes of the configuration channel.
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_EDGE_DEBOUNCE   = 2'd0,
        CFG_STEP_LOCKOUT    = 2'd1,
        CFG_BUTTON_DEBOUNCE = 2'd2
    } cfg_index_t;

    // Two's complement codes of the held rotation.
    localparam logic signed [1:0] ROT_NONE  = 2'sb00;
    localparam logic signed [1:0] ROT_PLUS  = 2'sb01;
    localparam logic signed [1:0] ROT_MINUS = 2'sb11;

    // Timing register set.
    typedef struct packed {
        logic [CFG_WIDTH-1:0] edge_debounce_ms;
        logic [CFG_WIDTH-1:0] step_lockout_ms;
        logic [CFG_WIDTH-1:0] press_holdoff_ms;
    } cfg_t;

    // Held values that software reads.
    typedef struct packed {
        logic signed [1:0] rotation;
        logic              press;
    } held_t;

    // Pin levels and request of one tick.
    typedef struct packed {
        logic read_clear;
        logic switch_level;
        logic dt_level;
        logic clk_level;
    } pins_t;

endpackage

@@ sv/red_tick.sv @@
module red_tick #(
    parameter int TIME_WIDTH = red_pkg::TIME_WIDTH_DEF
) (
    input  red_pkg::cfg_t          cfg,
    input  red_pkg::pins_t         pins,
    input  logic                   prev_clock,
    input  logic                   prev_switch,
    input  logic [TIME_WIDTH-1:0]  since_edge,
    input  logic [TIME_WIDTH-1:0]  since_step,
    input  logic [TIME_WIDTH-1:0]  since_press,
    input  red_pkg::held_t         held,
    output logic [TIME_WIDTH-1:0]  since_edge_next,
    output logic [TIME_WIDTH-1:0]  since_step_next,
    output logic [TIME_WIDTH-1:0]  since_press_next,
    output red_pkg::held_t         shown,
    output red_pkg::held_t         held_next
);

    // Compare width covers both the counters and the registers.
    localparam int CMP_W = (TIME_WIDTH > red_pkg::CFG_WIDTH) ? TIME_WIDTH : red_pkg::CFG_WIDTH;
    localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

    logic [TIME_WIDTH-1:0] edge_inc;
    logic [TIME_WIDTH-1:0] step_inc;
    logic [TIME_WIDTH-1:0] press_inc;
    logic                  edge_ok;
    logic                  step_ok;
    logic                  press_ok;

    // Elapsed counters advance by one tick and stop at all ones.
    always_comb
    begin
        edge_inc  = (since_edge  == TIME_MAX) ? since_edge  : since_edge  + 1'b1;
        step_inc  = (since_step  == TIME_MAX) ? since_step  : since_step  + 1'b1;
        press_inc = (since_press == TIME_MAX) ? since_press : since_press + 1'b1;
    end

    // Event qualification against the timing registers.
    always_comb
    begin
        edge_ok  = (pins.clk_level != prev_clock) &&
                   (CMP_W'(edge_inc) > CMP_W'(cfg.edge_debounce_ms));
        step_ok  = edge_ok && !pins.clk_level &&
                   (CMP_W'(step_inc) > CMP_W'(cfg.step_lockout_ms));
        press_ok = prev_switch && !pins.switch_level &&
                   (CMP_W'(press_inc) > CMP_W'(cfg.press_holdoff_ms));
    end

    // An accepted event restarts its counter and updates the held values.
    always_comb
    begin
        since_edge_next  = edge_ok  ? '0 : edge_inc;
        since_step_next  = step_ok  ? '0 : step_inc;
        since_press_next = press_ok ? '0 : press_inc;

        shown = held;
        if (step_ok)
        begin
            shown.rotation = pins.dt_level ? red_pkg::ROT_PLUS : red_pkg::ROT_MINUS;
        end
        if (press_ok)
        begin
            shown.press = 1'b1;
        end

        held_next = shown;
        if (pins.read_clear)
        begin
            held_next.rotation = red_pkg::ROT_NONE;
            held_next.press    = 1'b0;
        end
    end

endmodule

@@ sv/rotary_encoder_debounced_step.sv @@
// Channel  Direction  Payload (lowest bit first)                     Transaction
// s_*      in         clk_level, dt_level, switch_level, read_clear  one millisecond tick
// m_*      out        rotation_step[1:0], button_event               one result per tick
// cfg_*    in         cfg_index selects register, cfg_data value     one register write
//
// Each tick's result is registered and shown in the cycle after it is accepted; a tick can be
// accepted in every cycle. The rate is set by the single output register:
// s_tready is low only while a result waits and m_tready is low.
// Reset restores the timing registers to 5, 20 and 50 ms and clears the held values.
// The configuration channel is always ready.
module rotary_encoder_debounced_step #(
    parameter int TIME_WIDTH = red_pkg::TIME_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // Fields: clk_level, dt_level, switch_level, read_clear, zero padding.
    input  logic [red_pkg::IN_DATA_WIDTH-1:0]      s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // Fields: rotation_step[1:0], button_event, zero padding.
    output logic [red_pkg::OUT_DATA_WIDTH-1:0]     m_tdata,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [red_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [red_pkg::CFG_WIDTH-1:0]          cfg_data
);

    red_pkg::cfg_t         cfg_reg;
    logic                  prev_clock_reg;
    logic                  prev_switch_reg;
    logic [TIME_WIDTH-1:0] since_edge_reg;
    logic [TIME_WIDTH-1:0] since_step_reg;
    logic [TIME_WIDTH-1:0] since_press_reg;
    red_pkg::held_t        held_reg;
    logic                  m_tvalid_reg;
    red_pkg::held_t        result_reg;

    red_pkg::pins_t        pins;
    logic [TIME_WIDTH-1:0] since_edge_next;
    logic [TIME_WIDTH-1:0] since_step_next;
    logic [TIME_WIDTH-1:0] since_press_next;
    red_pkg::held_t        shown;
    red_pkg::held_t        held_next;
    logic                  s_accept;

    // Handshakes.
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign pins      = red_pkg::pins_t'(s_tdata[3:0]);

    // Timing register writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.edge_debounce_ms <= red_pkg::CFG_WIDTH'(5);
            cfg_reg.step_lockout_ms  <= red_pkg::CFG_WIDTH'(20);
            cfg_reg.press_holdoff_ms <= red_pkg::CFG_WIDTH'(50);
        end
        else if (cfg_valid)
        begin
            case (red_pkg::cfg_index_t'(cfg_index))
                red_pkg::CFG_EDGE_DEBOUNCE:   cfg_reg.edge_debounce_ms <= cfg_data;
                red_pkg::CFG_STEP_LOCKOUT:    cfg_reg.step_lockout_ms  <= cfg_data;
                red_pkg::CFG_BUTTON_DEBOUNCE: cfg_reg.press_holdoff_ms <= cfg_data;
                default:                      ;
            endcase
        end
    end

    // Per-tick decode logic.
    red_tick #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_tick (
        .cfg              (cfg_reg),
        .pins             (pins),
        .prev_clock       (prev_clock_reg),
        .prev_switch      (prev_switch_reg),
        .since_edge       (since_edge_reg),
        .since_step       (since_step_reg),
        .since_press      (since_press_reg),
        .held             (held_reg),
        .since_edge_next  (since_edge_next),
        .since_step_next  (since_step_next),
        .since_press_next (since_press_next),
        .shown            (shown),
        .held_next        (held_next)
    );

    // Decoder state advances once per accepted tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_clock_reg  <= 1'b1;
            prev_switch_reg <= 1'b1;
            since_edge_reg  <= '0;
            since_step_reg  <= '0;
            since_press_reg <= '0;
            held_reg        <= '0;
        end
        else if (s_accept)
        begin
            prev_clock_reg  <= pins.clk_level;
            prev_switch_reg <= pins.switch_level;
            since_edge_reg  <= since_edge_next;
            since_step_reg  <= since_step_next;
            since_press_reg <= since_press_next;
            held_reg        <= held_next;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    // Result payload, loaded with each accepted tick.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            result_reg <= shown;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(red_pkg::OUT_DATA_WIDTH-3){1'b0}}, result_reg.press,
                       result_reg.rotation};

endmodule

@@ dv/tb_top.sv @@
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TW = red_pkg::TIME_WIDTH_DEF;
    localparam int MAX_REPORTS = 10;
    localparam logic [red_pkg::CFG_INDEX_WIDTH-1:0] CFG_UNMAPPED = 2'd3;
    localparam logic [red_pkg::CFG_WIDTH-1:0] CFG_TOP = 16'd65534;
    localparam logic [TW-1:0] AGE_MAX = '1;

    logic clk;
    logic rst_n;
    logic s_tvalid = 1'b0;
    logic s_tready;
    // Fields: clk_level, dt_level, switch_level, read_clear, zero padding.
    logic [red_pkg::IN_DATA_WIDTH-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    // Fields: rotation_step[1:0], button_event, zero padding.
    logic [red_pkg::OUT_DATA_WIDTH-1:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [red_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [red_pkg::CFG_WIDTH-1:0] cfg_data = '0;

    // Mirror of the timing registers.
    logic [red_pkg::CFG_WIDTH-1:0] edge_limit = 16'd5;
    logic [red_pkg::CFG_WIDTH-1:0] step_limit = 16'd20;
    logic [red_pkg::CFG_WIDTH-1:0] press_limit = 16'd50;

    // Mirror of the decoder state.
    logic clk_seen = 1'b1;
    logic sw_seen = 1'b1;
    logic [TW-1:0] edge_age = '0;
    logic [TW-1:0] step_age = '0;
    logic [TW-1:0] press_age = '0;
    logic signed [1:0] rot_held = red_pkg::ROT_NONE;
    logic press_held = 1'b0;

    red_pkg::held_t pending_readouts[$];
    int mismatches = 0;
    bit no_gaps = 1'b0;
    int hold_off_cycles = 0;
    red_pkg::pins_t drive_pins = '0;

    rotary_encoder_debounced_step u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("rotary_encoder_debounced_step regression: fail");
        $finish;
    end

    function automatic logic [TW-1:0] age_up(input logic [TW-1:0] age);
        return (age == AGE_MAX) ? age : age + 1'b1;
    endfunction

    // One millisecond tick of the decoder: returns the held values shown for it.
    function automatic red_pkg::held_t decode_tick(input red_pkg::pins_t p);
        red_pkg::held_t shown;
        edge_age = age_up(edge_age);
        step_age = age_up(step_age);
        press_age = age_up(press_age);

        // Encoder clock: debounce, then a falling edge may give a step.
        if (p.clk_level != clk_seen && edge_age > edge_limit)
        begin
            edge_age = '0;
            if (!p.clk_level && step_age > step_limit)
            begin
                step_age = '0;
                rot_held = p.dt_level ? red_pkg::ROT_PLUS : red_pkg::ROT_MINUS;
            end
        end
        clk_seen = p.clk_level;

        // Button: a press is a release-to-pressed edge outside the debounce time.
        if (p.switch_level != sw_seen && !p.switch_level && press_age > press_limit)
        begin
            press_age = '0;
            press_held = 1'b1;
        end
        sw_seen = p.switch_level;

        shown.rotation = rot_held;
        shown.press = press_held;
        if (p.read_clear)
        begin
            rot_held = red_pkg::ROT_NONE;
            press_held = 1'b0;
        end
        return shown;
    endfunction

    function automatic red_pkg::pins_t pin_levels(input bit clk_l, input bit dt_l,
                                                  input bit sw_l, input bit rd_l);
        red_pkg::pins_t p;
        p.clk_level = clk_l;
        p.dt_level = dt_l;
        p.switch_level = sw_l;
        p.read_clear = rd_l;
        return p;
    endfunction

    function automatic int idle_draw();
        if (no_gaps)
            return 0;
        return $urandom_range(0, 6);
    endfunction

    task automatic flag_mismatch(input string what, input logic [7:0] exp_v,
                                 input logic [7:0] act_v);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, exp_v, act_v);
    endtask

    // Result checking and prediction, both on the sampled values at the rising edge.
    always @(posedge clk)
    begin : check_p
        red_pkg::held_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_readouts.size() == 0)
                    flag_mismatch("unexpected result", 8'h00, m_tdata);
                else
                begin
                    want = pending_readouts.pop_front();
                    if (m_tdata[1:0] !== want.rotation)
                        flag_mismatch("rotation_step", {6'b0, want.rotation},
                                      {6'b0, m_tdata[1:0]});
                    if (m_tdata[2] !== want.press)
                        flag_mismatch("button_event", {7'b0, want.press}, {7'b0, m_tdata[2]});
                    if (m_tdata[red_pkg::OUT_DATA_WIDTH-1:3] !== '0)
                        flag_mismatch("padding", 8'h00,
                                      8'(m_tdata[red_pkg::OUT_DATA_WIDTH-1:3]));
                end
            end
            if (s_tvalid && s_tready)
                pending_readouts.push_back(decode_tick(red_pkg::pins_t'(s_tdata[3:0])));
        end
    end

    // Result receiver: random stalls per transaction, plus a long hold-off on request.
    initial
    begin : receiver_p
        int stall;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = idle_draw();
            if (hold_off_cycles > 0)
            begin
                stall = hold_off_cycles;
                hold_off_cycles = 0;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            @(negedge clk);
        end
    end

    // Offers one tick and returns just after the edge at which it is taken.
    task automatic push_tick(input red_pkg::pins_t p);
        int gap;
        gap = idle_draw();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(red_pkg::IN_DATA_WIDTH-4){1'b0}}, p};
        do @(posedge clk); while (!s_tready);
    endtask

    // Stops offering ticks and waits until every result has been taken.
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_readouts.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [red_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             input logic [red_pkg::CFG_WIDTH-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            red_pkg::CFG_EDGE_DEBOUNCE:   edge_limit = val;
            red_pkg::CFG_STEP_LOCKOUT:    step_limit = val;
            red_pkg::CFG_BUTTON_DEBOUNCE: press_limit = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_timing(input logic [red_pkg::CFG_WIDTH-1:0] edge_ms,
                              input logic [red_pkg::CFG_WIDTH-1:0] step_ms,
                              input logic [red_pkg::CFG_WIDTH-1:0] button_ms);
        write_reg(red_pkg::CFG_EDGE_DEBOUNCE, edge_ms);
        write_reg(red_pkg::CFG_STEP_LOCKOUT, step_ms);
        write_reg(red_pkg::CFG_BUTTON_DEBOUNCE, button_ms);
    endtask

    // Free-running pin noise: each pin toggles with the given odds (one in n).
    task automatic scramble_pins(input int count, input int clk_odds, input int sw_odds);
        red_pkg::pins_t p;
        p = drive_pins;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(1, clk_odds) == 1)
                p.clk_level = ~p.clk_level;
            if ($urandom_range(1, sw_odds) == 1)
                p.switch_level = ~p.switch_level;
            p.dt_level = 1'($urandom_range(0, 1));
            p.read_clear = ($urandom_range(0, 3) == 0);
            push_tick(p);
        end
        drive_pins = p;
    endtask

    // Half a detent: contact bounce, then the clock pin settles at a level for a while.
    task automatic detent_half(input bit level, input bit dt_l, input int hold_max,
                               inout int sent);
        red_pkg::pins_t p;
        int flickers;
        int hold;
        p = drive_pins;
        flickers = 2 * $urandom_range(0, 2);
        hold = $urandom_range(1, hold_max);
        for (int i = 0; i < flickers + hold; i++)
        begin
            p.clk_level = (i < flickers) ? ~p.clk_level : level;
            p.dt_level = (i < flickers) ? bit'($urandom_range(0, 1)) : dt_l;
            if ($urandom_range(0, 9) == 0)
                p.switch_level = ~p.switch_level;
            p.read_clear = ($urandom_range(0, 4) == 0);
            push_tick(p);
            sent++;
        end
        drive_pins = p;
    endtask

    // Well-formed turns in random directions with bounce and random dwell times.
    task automatic turn_detents(input int count, input int hold_max);
        int sent;
        bit dir;
        sent = 0;
        while (sent < count)
        begin
            dir = 1'($urandom_range(0, 1));
            detent_half(1'b0, dir, hold_max, sent);
            detent_half(1'b1, ~dir, hold_max, sent);
        end
    endtask

    // Hand-picked ticks with short timing: lockout, debounce, overwrite and read-clear.
    task automatic test_directed_sequences();
        set_timing(16'd1, 16'd3, 16'd2);
        push_tick(pin_levels(1, 1, 1, 0));   // idle
        push_tick(pin_levels(0, 1, 0, 0));   // clock edge taken, step locked out
        push_tick(pin_levels(1, 1, 1, 0));   // clock change too soon
        push_tick(pin_levels(1, 1, 1, 0));
        push_tick(pin_levels(0, 1, 0, 0));   // step +1 and press
        push_tick(pin_levels(1, 0, 1, 1));   // read shows both, then clears
        push_tick(pin_levels(1, 0, 1, 0));
        push_tick(pin_levels(0, 0, 1, 0));   // clock edge taken inside lockout
        push_tick(pin_levels(1, 0, 1, 0));
        push_tick(pin_levels(1, 0, 1, 0));
        push_tick(pin_levels(0, 0, 1, 0));   // step -1
        push_tick(pin_levels(0, 1, 0, 0));   // press while a step is held
        push_tick(pin_levels(1, 1, 0, 0));
        push_tick(pin_levels(1, 1, 1, 0));
        push_tick(pin_levels(1, 1, 1, 0));
        push_tick(pin_levels(0, 1, 1, 0));   // +1 overwrites the held -1
        push_tick(pin_levels(0, 0, 0, 1));
        push_tick(pin_levels(1, 0, 1, 0));
        push_tick(pin_levels(0, 0, 0, 0));
        push_tick(pin_levels(1, 1, 1, 1));
        drive_pins = pin_levels(1, 1, 1, 1);
        wait_idle();
    endtask

    // Registers at zero and one below their top value, and a write to an unmapped index.
    task automatic test_register_extremes();
        set_timing('0, '0, '0);
        scramble_pins(100, 2, 2);
        wait_idle();
        set_timing(CFG_TOP, CFG_TOP, CFG_TOP);
        scramble_pins(50, 2, 2);
        wait_idle();
        write_reg(CFG_UNMAPPED, red_pkg::CFG_WIDTH'($urandom_range(0, 65535)));
        scramble_pins(10, 2, 2);
        wait_idle();
    endtask

    // Turns at the timing that reset selects.
    task automatic test_default_timing();
        set_timing(16'd5, 16'd20, 16'd50);
        turn_detents(300, 30);
        wait_idle();
    endtask

    // Several short random timings, each with noise or with detent turns.
    task automatic test_random_settings();
        for (int phase = 0; phase < 4; phase++)
        begin
            no_gaps = ($urandom_range(0, 3) == 0);
            set_timing(red_pkg::CFG_WIDTH'($urandom_range(0, 4)),
                       red_pkg::CFG_WIDTH'($urandom_range(0, 12)),
                       red_pkg::CFG_WIDTH'($urandom_range(0, 10)));
            if (phase % 2 == 0)
                scramble_pins(150, 3, 4);
            else
                turn_detents(150, 8);
            wait_idle();
        end
        no_gaps = 1'b0;
    endtask

    // Receiver holds off for a long stretch while ticks keep coming.
    task automatic test_output_backpressure();
        set_timing(16'd1, 16'd2, 16'd3);
        no_gaps = 1'b1;
        hold_off_cycles = 120;
        scramble_pins(40, 2, 3);
        no_gaps = 1'b0;
        wait_idle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_sequences();
        test_register_extremes();
        test_default_timing();
        test_random_settings();
        test_output_backpressure();

        repeat (4) @(posedge clk);
        if (mismatches == 0 && pending_readouts.size() == 0)
            $display("rotary_encoder_debounced_step regression: pass");
        else
            $display("rotary_encoder_debounced_step regression: fail");
        $finish;
    end

endmodule
